[hdl/chash_pkg.sv]
package chash_pkg;

   localparam int NUM_BUCKETS_DEF = 179;
   localparam int POOL_NODES_DEF  = 1024;
   localparam int KEY_WIDTH       = 31;
   localparam int PAYLOAD_WIDTH   = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_BKT_RD,
      ST_BKT,
      ST_INS_FREE,
      ST_INS_LINK,
      ST_WALK,
      ST_REM_PREV
   } state_type;

   typedef struct packed {
      logic [1:0]               operation;
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [PAYLOAD_WIDTH-1:0] found_payload;
   } rsp_type;

endpackage

[hdl/chained_hash_table.sv]
// Chained hash table with a bounded node pool.
// A request word is taken at a rising edge where start is high and busy is low. It carries an
// operation (insert, search or remove), a key and, for an insert, a payload. Every request
// produces exactly one response word, shown on rsp_word for one cycle while rsp_strobe is
// high; the receiver cannot stall it and must take it in that cycle.
// The bucket is the key modulo NUM_BUCKETS, formed four key bits per cycle.
// Bucket head and tail pointers live in one memory, node key, payload and link in another,
// both with registered read data and one read and one write port.
// A search, insert or remove first hashes the key and reads the bucket. An insert then takes
// the free node and writes it and the bucket, and rewrites the old tail's link when the bucket
// already holds nodes; a full pool answers straight after the bucket read, as does a search or
// remove of an empty bucket. Otherwise a search or remove walks the chain, and a remove of a
// node that is not first then rewrites its predecessor's link. An unused operation code answers
// in the cycle after it is taken. The node memory read port walks one node per cycle and is the
// loop that sets the rate. One request is in flight at a time. After reset a clearing pass
// empties every bucket and links the pool into the free list; busy stays high until it ends.
module chained_hash_table #(
   parameter int NUM_BUCKETS = chash_pkg::NUM_BUCKETS_DEF,
   parameter int POOL_NODES  = chash_pkg::POOL_NODES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  chash_pkg::req_type req_word,
   output logic               rsp_strobe,
   output chash_pkg::rsp_type rsp_word
);

   import chash_pkg::*;

   localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int NAW  = $clog2(POOL_NODES);
   localparam int PW   = $clog2(POOL_NODES + 1);
   localparam int NW   = KEY_WIDTH + PAYLOAD_WIDTH + PW;
   localparam int MAXD = (NUM_BUCKETS > POOL_NODES) ? NUM_BUCKETS : POOL_NODES;
   localparam int CW   = $clog2(MAXD + 1);
   localparam logic [PW-1:0] NIL  = PW'(POOL_NODES);
   localparam logic [BW:0]   NB_C = (BW + 1)'(NUM_BUCKETS);

   state_type                state_ff, state_in;
   logic [CW-1:0]            clr_ff, clr_in;
   logic [1:0]               op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [31:0]              kshift_ff, kshift_in;
   logic [BW-1:0]            rem_ff, rem_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [PW-1:0]            head_ff, head_in;
   logic [PW-1:0]            tail_ff, tail_in;
   logic [PW-1:0]            cur_ff, cur_in;
   logic [PW-1:0]            prev_ff, prev_in;
   logic [PW-1:0]            nxt_ff, nxt_in;
   logic [PW-1:0]            free_ff, free_in;
   logic [NW-1:0]            prev_word_ff, prev_word_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [BW-1:0]            rem_next;
   logic                     bkt_we, bkt_re;
   logic [BW-1:0]            bkt_wa, bkt_ra;
   logic [2*PW-1:0]          bkt_wd, bkt_rd;
   logic                     node_we, node_re;
   logic [NAW-1:0]           node_wa, node_ra;
   logic [NW-1:0]            node_wd, node_rd;
   logic [KEY_WIDTH-1:0]     rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;
   logic [PW-1:0]            rd_link;
   logic [PW-1:0]            bkt_head, bkt_tail;

   assign rd_key   = node_rd[NW-1 -: KEY_WIDTH];
   assign rd_pay   = node_rd[PW +: PAYLOAD_WIDTH];
   assign rd_link  = node_rd[PW-1:0];
   assign bkt_head = bkt_rd[2*PW-1:PW];
   assign bkt_tail = bkt_rd[PW-1:0];

   chash_ram #(.WIDTH(2 * PW), .DEPTH(NUM_BUCKETS), .ADDR_WIDTH(BW)) u_bucket_ram (
      .clock      (clock),
      .wr_en      (bkt_we),
      .wr_addr    (bkt_wa),
      .wr_data    (bkt_wd),
      .rd_en      (bkt_re),
      .rd_addr    (bkt_ra),
      .rd_data_ff (bkt_rd)
   );

   chash_ram #(.WIDTH(NW), .DEPTH(POOL_NODES), .ADDR_WIDTH(NAW)) u_node_ram (
      .clock      (clock),
      .wr_en      (node_we),
      .wr_addr    (node_wa),
      .wr_data    (node_wd),
      .rd_en      (node_re),
      .rd_addr    (node_ra),
      .rd_data_ff (node_rd)
   );

   always_comb begin
      logic [BW-1:0] r;
      logic [BW:0]   t;
      r = rem_ff;
      for (int i = 0; i < 4; i++) begin
         t = {r, kshift_ff[31-i]};
         if (t >= NB_C) begin
            t = t - NB_C;
         end
         r = t[BW-1:0];
      end
      rem_next = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      pay_ff       <= pay_in;
      kshift_ff    <= kshift_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      nxt_ff       <= nxt_in;
      prev_word_ff <= prev_word_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      kshift_in    = kshift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      nxt_in       = nxt_ff;
      free_in      = free_ff;
      prev_word_in = prev_word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      bkt_we       = 1'b0;
      bkt_wa       = rem_ff;
      bkt_wd       = {head_ff, tail_ff};
      bkt_re       = 1'b0;
      bkt_ra       = rem_ff;
      node_we      = 1'b0;
      node_wa      = cur_ff[NAW-1:0];
      node_wd      = {key_ff, pay_ff, NIL};
      node_re      = 1'b0;
      node_ra      = cur_ff[NAW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            bkt_we  = (clr_ff < CW'(NUM_BUCKETS));
            bkt_wa  = clr_ff[BW-1:0];
            bkt_wd  = {NIL, NIL};
            node_we = (clr_ff < CW'(POOL_NODES));
            node_wa = clr_ff[NAW-1:0];
            node_wd = {{KEY_WIDTH{1'b0}}, {PAYLOAD_WIDTH{1'b0}}, PW'(clr_ff + 1'b1)};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CW'(MAXD - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in     = req_word.operation;
               key_in    = req_word.key;
               pay_in    = req_word.payload;
               kshift_in = {1'b0, req_word.key};
               rem_in    = '0;
               cnt_in    = '0;
               if (req_word.operation == OP_INSERT || req_word.operation == OP_SEARCH ||
                   req_word.operation == OP_REMOVE) begin
                  state_in = ST_HASH;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_DONE, found_payload: '0};
               end
            end
         end
         ST_HASH: begin
            rem_in    = rem_next;
            kshift_in = {kshift_ff[27:0], 4'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_BKT_RD;
            end
         end
         ST_BKT_RD: begin
            bkt_re   = 1'b1;
            state_in = ST_BKT;
         end
         ST_BKT: begin
            head_in = bkt_head;
            tail_in = bkt_tail;
            if (op_ff == OP_INSERT) begin
               if (free_ff == NIL) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_FULL, found_payload: '0};
                  state_in     = ST_IDLE;
               end else begin
                  node_re  = 1'b1;
                  node_ra  = free_ff[NAW-1:0];
                  cur_in   = free_ff;
                  state_in = ST_INS_FREE;
               end
            end else if (bkt_head == NIL) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STAT_MISS, found_payload: '0};
               state_in     = ST_IDLE;
            end else begin
               node_re  = 1'b1;
               node_ra  = bkt_head[NAW-1:0];
               cur_in   = bkt_head;
               prev_in  = NIL;
               state_in = ST_WALK;
            end
         end
         ST_INS_FREE: begin
            free_in = rd_link;
            node_we = 1'b1;
            bkt_we  = 1'b1;
            if (head_ff == NIL || tail_ff == NIL) begin
               bkt_wd       = {cur_ff, cur_ff};
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STAT_DONE, found_payload: '0};
               state_in     = ST_IDLE;
            end else begin
               bkt_wd   = {head_ff, cur_ff};
               node_re  = 1'b1;
               node_ra  = tail_ff[NAW-1:0];
               state_in = ST_INS_LINK;
            end
         end
         ST_INS_LINK: begin
            node_we      = 1'b1;
            node_wa      = tail_ff[NAW-1:0];
            node_wd      = {rd_key, rd_pay, cur_ff};
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STAT_DONE, found_payload: '0};
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            if (rd_key == key_ff) begin
               if (op_ff == OP_SEARCH) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_DONE, found_payload: rd_pay};
                  state_in     = ST_IDLE;
               end else begin
                  bkt_we  = 1'b1;
                  bkt_wd  = {(prev_ff == NIL) ? rd_link : head_ff,
                             (tail_ff == cur_ff) ? prev_ff : tail_ff};
                  node_we = 1'b1;
                  node_wd = {rd_key, rd_pay, free_ff};
                  free_in = cur_ff;
                  nxt_in  = rd_link;
                  if (prev_ff == NIL) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STAT_DONE, found_payload: '0};
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_REM_PREV;
                  end
               end
            end else begin
               prev_in      = cur_ff;
               prev_word_in = node_rd;
               cur_in       = rd_link;
               if (rd_link == NIL) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_MISS, found_payload: '0};
                  state_in     = ST_IDLE;
               end else begin
                  node_re = 1'b1;
                  node_ra = rd_link[NAW-1:0];
               end
            end
         end
         ST_REM_PREV: begin
            node_we      = 1'b1;
            node_wa      = prev_ff[NAW-1:0];
            node_wd      = {prev_word_ff[NW-1:PW], nxt_ff};
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STAT_DONE, found_payload: '0};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= NIL)
      else $error("free list head out of range");
   a_no_idle_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!node_we && !bkt_we))
      else $error("memory written while idle");
   a_walk_reads_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cur_ff != NIL))
      else $error("chain walk on a null node");

endmodule

[hdl/chash_ram.sv]
module chash_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 2,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[test/chained_hash_table_tb.sv]
module chained_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import chash_pkg::*;

   localparam int NB = NUM_BUCKETS_DEF;
   localparam int NP = POOL_NODES_DEF;
   localparam int NIL = NP;
   localparam int STALL_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   chained_hash_table dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   // Shadow copy of the table.
   int                     head_of[NB];
   int                     tail_of[NB];
   logic [KEY_WIDTH-1:0]   key_of[NP];
   logic [PAYLOAD_WIDTH-1:0] pay_of[NP];
   int                     link_of[NP];
   int                     free_top;

   rsp_type pending_rsp[$];
   int      failures;
   int      quiet_cycles;
   int      idle_pct;
   logic [KEY_WIDTH-1:0] live_keys[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type table_update(req_type w);
      rsp_type r;
      int b, n, cur, prev, steps, nxt;
      r.status = STAT_DONE;
      r.found_payload = '0;
      b = int'(w.key % NB);
      if (w.operation == OP_INSERT) begin
         n = free_top;
         if (n >= NIL) begin
            r.status = STAT_FULL;
         end else begin
            free_top = link_of[n];
            key_of[n] = w.key;
            pay_of[n] = w.payload;
            link_of[n] = NIL;
            if (head_of[b] >= NIL || tail_of[b] >= NIL) head_of[b] = n;
            else link_of[tail_of[b]] = n;
            tail_of[b] = n;
         end
      end else if (w.operation == OP_SEARCH || w.operation == OP_REMOVE) begin
         prev = NIL;
         cur = head_of[b];
         steps = 0;
         while (cur < NIL && steps < NP && key_of[cur] != w.key) begin
            prev = cur;
            cur = link_of[cur];
            steps++;
         end
         if (cur >= NIL || steps >= NP) begin
            r.status = STAT_MISS;
         end else if (w.operation == OP_SEARCH) begin
            r.found_payload = pay_of[cur];
         end else begin
            nxt = link_of[cur];
            if (prev >= NIL) head_of[b] = nxt;
            else link_of[prev] = nxt;
            if (tail_of[b] == cur) tail_of[b] = prev;
            link_of[cur] = free_top;
            free_top = cur;
         end
      end
      return r;
   endfunction

   task automatic send_word(logic [1:0] op, logic [KEY_WIDTH-1:0] k,
                            logic [PAYLOAD_WIDTH-1:0] p);
      req_type w;
      w.operation = op;
      w.key = k;
      w.payload = p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(table_update(w));
      if (op == OP_INSERT) live_keys.push_back(k);
   endtask

   function automatic logic [KEY_WIDTH-1:0] pick_key();
      if (live_keys.size() > 0 && $urandom_range(3) != 0)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      if ($urandom_range(1)) return KEY_WIDTH'($urandom_range(NB * 3));
      return KEY_WIDTH'($urandom());
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            failures++;
         end else begin
            if (rsp_word.status !== pending_rsp[0].status ||
                rsp_word.found_payload !== pending_rsp[0].found_payload) begin
               $display("%0t: expected %p, actual %p", $time, pending_rsp[0], rsp_word);
               failures++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      send_word(OP_SEARCH, '0, '1);
      send_word(OP_REMOVE, '1, '0);
      send_word(OP_INSERT, '0, '1);
      send_word(OP_INSERT, '1, 32'h5555_AAAA);
      send_word(OP_INSERT, KEY_WIDTH'(NB), 32'h1234_5678);
      send_word(OP_INSERT, '0, 32'hDEAD_BEEF);
      send_word(OP_SEARCH, '0, '0);
      send_word(OP_SEARCH, KEY_WIDTH'(NB), '0);
      send_word(OP_SEARCH, '1, '1);
      send_word(OP_REMOVE, KEY_WIDTH'(NB), '0);
      send_word(OP_REMOVE, '0, '0);
      send_word(OP_SEARCH, '0, '0);
      send_word(OP_UNUSED, '1, '1);
      send_word(OP_REMOVE, '1, '0);
      send_word(OP_SEARCH, '1, '0);
      send_word(OP_REMOVE, '0, '0);
      send_word(OP_SEARCH, '0, '0);
   endtask

   task automatic test_random_mix(int count);
      int r;
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         op = r < 40 ? OP_INSERT : r < 70 ? OP_SEARCH : r < 97 ? OP_REMOVE : OP_UNUSED;
         send_word(op, pick_key(), $urandom());
      end
   endtask

   // Fills the pool past capacity, then removes part of it again.
   task automatic test_pool_full();
      idle_pct = 0;
      for (int i = 0; i < NP + 3; i++)
         send_word(OP_INSERT, KEY_WIDTH'($urandom_range(NB * 4)), $urandom());
      send_word(OP_SEARCH, pick_key(), '0);
      for (int i = 0; i < 200; i++) send_word(OP_REMOVE, pick_key(), '0);
   endtask

   initial begin
      failures = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      start = 1'b0;
      req_word = '0;
      reset = 1'b1;
      for (int i = 0; i < NB; i++) begin
         head_of[i] = NIL;
         tail_of[i] = NIL;
      end
      for (int i = 0; i < NP; i++) begin
         key_of[i] = '0;
         pay_of[i] = '0;
         link_of[i] = i + 1;
      end
      free_top = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_pct = 0;
      test_random_mix(150);
      idle_pct = 63;
      test_random_mix(150);
      idle_pct = 9;
      test_random_mix(150);
      test_pool_full();
      idle_pct = 63;
      test_random_mix(50);
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[chained_hash_table.f]
hdl/chash_pkg.sv
hdl/chash_ram.sv
hdl/chained_hash_table.sv
test/chained_hash_table_tb.sv
